[rtl/best_fit_block_allocator_assert.svh]
// Assertion macros for the best-fit block allocator.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bfa_pkg.sv]
// Shared codes and defaults for the best-fit block allocator.
// No dependencies; imported by every module of the block.
`default_nettype none
package bfa_pkg;
    localparam int MAX_BLOCKS_DEF   = 256;
    localparam int HEADER_BYTES_DEF = 32;
    localparam int ALIGN_BYTES_DEF  = 8;

    localparam logic [31:0] ARENA_BYTES_RST = 32'(1024 * 1024 * 10);
    localparam logic [15:0] MIN_SPLIT_RST   = 16'd16;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_INIT  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOM   = 2'd1;
    localparam logic [1:0] ST_NULL  = 2'd2;
    localparam logic [1:0] ST_NOBLK = 2'd3;

    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_BYTES  = 2'd1;
    localparam logic [1:0] CFG_MSPLIT = 2'd2;

    typedef logic [47:0] t_addr;
endpackage
`default_nettype wire

[rtl/bfa_mem.sv]
// Simple dual-port synchronous RAM: one write, one registered read per cycle.
// Uses bfa_pkg only for its default depth; holds entry tables.
`default_nettype none
module bfa_mem #(
    parameter int DEPTH = bfa_pkg::MAX_BLOCKS_DEF,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    import bfa_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/best_fit_block_allocator.sv]
// Best-fit block allocator. Items are taken one at a time. Initialize and a null release or
// query go straight to the result. Allocate rounds the size, then walks the block list,
// reading and checking one entry from the entry RAM per visited block, and decides. A split
// scans the slot table for a free slot and writes both halves; with a full table the block is
// taken whole. Release and size query scan the slot table at one entry a cycle; release then
// merges with free neighbors, and both hand over the result. Block state lives in two RAMs
// (offset/size/free/next and prev) plus one in-use flag per slot.
`default_nettype none
module best_fit_block_allocator #(
    parameter int MAX_BLOCKS   = bfa_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = bfa_pkg::ALIGN_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [47:0]   i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire logic [1:0]    i_opcode,
    input  wire logic [31:0]   i_request_size,
    input  wire bfa_pkg::t_addr i_data_address,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [1:0]         o_status,
    output bfa_pkg::t_addr     o_result_address,
    output logic [31:0]        o_block_bytes
);
    import bfa_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int LW = IW + 1;
    localparam int AW = 65 + LW;
    localparam logic [LW-1:0] NO_LINK = LW'(MAX_BLOCKS);
    localparam logic [6:0]    ALIGN7  = 7'(ALIGN_BYTES);
    localparam logic [31:0]   HDR32   = 32'(HEADER_BYTES);
    // Reciprocal of the alignment, exact for every 32-bit request.
    localparam int            RSH     = 32 + $clog2(ALIGN_BYTES);
    localparam logic [32:0]   RMUL    =
        33'(((65'd1 << RSH) + 65'(ALIGN_BYTES - 1)) / 65'(ALIGN_BYTES));

    localparam logic [3:0] S_IDLE = 4'd0,  S_ROUND = 4'd1,  S_WALK_RD = 4'd2,
                           S_WALK_EV = 4'd3, S_DECIDE = 4'd4, S_SLOT = 4'd5,
                           S_SPL1 = 4'd6,  S_SPL2 = 4'd7,  S_TAKE = 4'd8,
                           S_FIND = 4'd9,  S_REL_N = 4'd10, S_REL_NW = 4'd11,
                           S_REL_BW = 4'd12, S_REL_PW = 4'd13, S_DONE = 4'd14;

    logic [3:0]  r_state, n_state;
    logic [1:0]  r_op, n_op;
    logic [31:0] r_req, n_req, r_sh, n_sh;
    logic [47:0] r_t, n_t;
    logic [4:0]  r_cnt, n_cnt;
    logic [32:0] r_size, n_size;
    logic [LW-1:0] r_cur, n_cur, r_steps, n_steps, r_best, n_best;
    logic [LW-1:0] r_bnext, n_bnext, r_bprev, n_bprev, r_idx, n_idx;
    logic [31:0] r_boff, n_boff, r_bsize, n_bsize;
    logic        r_pv, n_pv;
    logic [IW-1:0] r_pidx, n_pidx, r_slot, n_slot;
    logic [MAX_BLOCKS-1:0] r_used, n_used;
    logic [1:0]  r_rstat, n_rstat;
    logic [47:0] r_raddr, n_raddr;
    logic [31:0] r_rbytes, n_rbytes;
    logic [47:0] r_base;
    logic [31:0] r_abytes;
    logic [15:0] r_msplit;
    logic        r_ovalid;
    logic [1:0]  r_ostat;
    logic [47:0] r_oaddr;
    logic [31:0] r_obytes;

    logic          a_we, a_re, b_we, b_re;
    logic [IW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
    logic [AW-1:0] a_wdata, a_rdata;
    logic [LW-1:0] b_wdata, b_rdata;

    logic [31:0]   d_off, d_size;
    logic          d_free;
    logic [LW-1:0] d_next;
    logic [6:0]    rs;
    logic          fits;
    logic [64:0]   quot_prod;

    assign d_off  = a_rdata[LW+64:LW+33];
    assign d_size = a_rdata[LW+32:LW+1];
    assign d_free = a_rdata[LW];
    assign d_next = a_rdata[LW-1:0];

    assign quot_prod = {33'd0, r_req} * {32'd0, RMUL};

    // Entry RAM: offset, payload size, free flag, next link.
    bfa_mem #(.DEPTH(MAX_BLOCKS), .WIDTH(AW)) u_entry (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_re(a_re), .i_raddr(a_raddr), .o_rdata(a_rdata)
    );
    // Prev-link RAM, kept apart so a neighbor's back link is a plain write.
    bfa_mem #(.DEPTH(MAX_BLOCKS), .WIDTH(LW)) u_prev (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_re(b_re), .i_raddr(b_raddr), .o_rdata(b_rdata)
    );

    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostat;
    assign o_result_address = r_oaddr;
    assign o_block_bytes    = r_obytes;

    always_comb begin
        n_state = r_state; n_op = r_op; n_req = r_req; n_sh = r_sh; n_t = r_t;
        n_cnt = r_cnt; n_size = r_size; n_cur = r_cur;
        n_steps = r_steps; n_best = r_best; n_bnext = r_bnext; n_bprev = r_bprev;
        n_idx = r_idx; n_boff = r_boff; n_bsize = r_bsize; n_pv = r_pv;
        n_pidx = r_pidx; n_slot = r_slot; n_used = r_used; n_rstat = r_rstat;
        n_raddr = r_raddr; n_rbytes = r_rbytes;
        a_we = 1'b0; a_waddr = '0; a_wdata = '0; a_re = 1'b0; a_raddr = '0;
        b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_re = 1'b0; b_raddr = '0;
        rs = '0;
        fits = d_free && ({1'b0, d_size} >= r_size);

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_opcode; n_req = i_request_size; n_sh = i_request_size;
                    n_rstat = ST_OK; n_raddr = '0; n_rbytes = '0;
                    n_t = i_data_address - r_base - 48'(HEADER_BYTES);
                    case (i_opcode)
                        OP_INIT: begin
                            n_rbytes = (r_abytes > HDR32) ? (r_abytes - HDR32) : 32'd0;
                            a_we = 1'b1; a_waddr = '0;
                            a_wdata = {32'd0, n_rbytes, 1'b1, NO_LINK};
                            b_we = 1'b1; b_waddr = '0; b_wdata = NO_LINK;
                            n_used = '0; n_used[0] = 1'b1;
                            n_state = S_DONE;
                        end
                        OP_ALLOC: begin
                            n_cnt = '0; n_state = S_ROUND;
                        end
                        default: begin
                            if (i_data_address == 48'd0) begin
                                n_rstat = ST_NULL; n_state = S_DONE;
                            end else begin
                                n_idx = '0; n_pv = 1'b0; n_state = S_FIND;
                            end
                        end
                    endcase
                end
            end
            // The first step takes the quotient by the alignment, the next the remainder
            // and the rounded size.
            S_ROUND: begin
                if (r_cnt == 5'd0) begin
                    n_sh = quot_prod[RSH +: 32]; n_cnt = 5'd1;
                end else begin
                    rs = 7'(r_req - r_sh * 32'(ALIGN_BYTES));
                    n_size = {1'b0, r_req} + ((rs == 7'd0) ? 33'd0 : 33'(ALIGN7 - rs));
                    n_best = NO_LINK; n_cur = '0; n_steps = '0;
                    n_state = r_used[0] ? S_WALK_RD : S_DECIDE;
                end
            end
            S_WALK_RD: begin
                a_re = 1'b1; a_raddr = r_cur[IW-1:0];
                n_state = S_WALK_EV;
            end
            S_WALK_EV: begin
                n_cur = d_next; n_steps = r_steps + 1'b1;
                n_state = (d_next != NO_LINK && n_steps != NO_LINK) ? S_WALK_RD : S_DECIDE;
                if (fits && (r_best == NO_LINK || d_size < r_bsize)) begin
                    n_best = r_cur; n_boff = d_off; n_bsize = d_size; n_bnext = d_next;
                    // An exact fit cannot be beaten, so the walk stops here.
                    if ({1'b0, d_size} == r_size) begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (r_best == NO_LINK) begin
                    n_rstat = ST_OOM; n_state = S_DONE;
                end else if ({2'b0, r_bsize} >
                             {1'b0, r_size} + 34'(HEADER_BYTES) + {18'd0, r_msplit}) begin
                    n_idx = '0; n_state = S_SLOT;
                end else begin
                    n_state = S_TAKE;
                end
            end
            S_SLOT: begin
                if (!r_used[r_idx[IW-1:0]]) begin
                    n_slot = r_idx[IW-1:0]; n_state = S_SPL1;
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (n_idx == NO_LINK) begin
                        n_state = S_TAKE;
                    end
                end
            end
            S_SPL1: begin
                a_we = 1'b1; a_waddr = r_slot;
                a_wdata = {r_boff + HDR32 + r_size[31:0], r_bsize - r_size[31:0] - HDR32,
                           1'b1, r_bnext};
                b_we = 1'b1; b_waddr = r_slot; b_wdata = r_best;
                n_used[r_slot] = 1'b1;
                n_state = S_SPL2;
            end
            S_SPL2: begin
                a_we = 1'b1; a_waddr = r_best[IW-1:0];
                a_wdata = {r_boff, r_size[31:0], 1'b0, {1'b0, r_slot}};
                b_we = (r_bnext != NO_LINK); b_waddr = r_bnext[IW-1:0];
                b_wdata = {1'b0, r_slot};
                n_raddr = r_base + 48'(r_boff) + 48'(HEADER_BYTES);
                n_rbytes = r_size[31:0];
                n_state = S_DONE;
            end
            S_TAKE: begin
                a_we = 1'b1; a_waddr = r_best[IW-1:0];
                a_wdata = {r_boff, r_bsize, 1'b0, r_bnext};
                n_raddr = r_base + 48'(r_boff) + 48'(HEADER_BYTES);
                n_rbytes = r_bsize;
                n_state = S_DONE;
            end
            // Reads one slot a cycle and checks the slot read the cycle before.
            S_FIND: begin
                a_re = (r_idx != NO_LINK); a_raddr = r_idx[IW-1:0];
                b_re = a_re; b_raddr = r_idx[IW-1:0];
                n_pv = a_re && r_used[r_idx[IW-1:0]];
                n_pidx = r_idx[IW-1:0];
                n_idx = r_idx + 1'b1;
                if (r_pv && {16'd0, d_off} == r_t) begin
                    n_best = {1'b0, r_pidx}; n_boff = d_off; n_bsize = d_size;
                    n_bnext = d_next; n_bprev = b_rdata;
                    if (r_op == OP_QUERY) begin
                        n_rbytes = d_size; n_state = S_DONE;
                    end else begin
                        n_state = S_REL_N;
                    end
                end else if (r_idx == NO_LINK) begin
                    n_rstat = ST_NOBLK; n_state = S_DONE;
                end
            end
            S_REL_N: begin
                a_re = (r_bnext != NO_LINK); a_raddr = r_bnext[IW-1:0];
                n_state = a_re ? S_REL_NW : S_REL_BW;
            end
            S_REL_NW: begin
                if (d_free) begin
                    n_bsize = r_bsize + HDR32 + d_size;
                    n_bnext = d_next;
                    b_we = (d_next != NO_LINK); b_waddr = d_next[IW-1:0]; b_wdata = r_best;
                    n_used[r_bnext[IW-1:0]] = 1'b0;
                end
                n_state = S_REL_BW;
            end
            // Writes the released block while reading its predecessor.
            S_REL_BW: begin
                a_we = 1'b1; a_waddr = r_best[IW-1:0];
                a_wdata = {r_boff, r_bsize, 1'b1, r_bnext};
                a_re = (r_bprev != NO_LINK); a_raddr = r_bprev[IW-1:0];
                n_state = a_re ? S_REL_PW : S_DONE;
            end
            S_REL_PW: begin
                if (d_free) begin
                    a_we = 1'b1; a_waddr = r_bprev[IW-1:0];
                    a_wdata = {d_off, d_size + HDR32 + r_bsize, 1'b1, r_bnext};
                    b_we = (r_bnext != NO_LINK); b_waddr = r_bnext[IW-1:0];
                    b_wdata = r_bprev;
                    n_used[r_best[IW-1:0]] = 1'b0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_base   <= '0;
            r_abytes <= ARENA_BYTES_RST;
            r_msplit <= MIN_SPLIT_RST;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            if (r_state == S_DONE && (!r_ovalid || !i_out_stall)) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE:   r_base   <= i_cfg_data;
                    CFG_BYTES:  r_abytes <= i_cfg_data[31:0];
                    CFG_MSPLIT: r_msplit <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_req <= n_req; r_sh <= n_sh; r_t <= n_t;
        r_cnt <= n_cnt; r_size <= n_size; r_cur <= n_cur; r_steps <= n_steps;
        r_best <= n_best; r_bnext <= n_bnext; r_bprev <= n_bprev; r_idx <= n_idx;
        r_boff <= n_boff; r_bsize <= n_bsize; r_pv <= n_pv; r_pidx <= n_pidx;
        r_slot <= n_slot; r_rstat <= n_rstat; r_raddr <= n_raddr; r_rbytes <= n_rbytes;
        if (r_state == S_DONE && (!r_ovalid || !i_out_stall)) begin
            r_ostat  <= r_rstat;
            r_oaddr  <= r_raddr;
            r_obytes <= r_rbytes;
        end
    end

`include "best_fit_block_allocator_assert.svh"

    `BFA_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, r_state != S_IDLE, "accepted beat did not start work")
    `BFA_ASSERT_NOW(a_split_slot_free, r_state == S_SPL1, !r_used[r_slot], "split into a used slot")
    `BFA_ASSERT_NOW(a_no_rw_collision, a_we && a_re, a_waddr != a_raddr, "entry RAM read and write collide")
endmodule
`default_nettype wire
